// ===== rtl/urppc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urppc_pkg
// Shared constants and types for the user range page permission check.
// ----------------------------------------------------------------------------
package urppc_pkg;

    // Window size in pages and derived widths
    localparam int TABLE_PAGES = 512;
    localparam int PAGE_W      = $clog2(TABLE_PAGES);
    localparam int PAGE_SHIFT  = 12;
    localparam int ADDR_W      = 64;
    localparam int VPN_W       = ADDR_W - PAGE_SHIFT;
    localparam int REG_W       = 10;
    localparam int CMP_W       = (PAGE_W > REG_W) ? PAGE_W : REG_W;
    localparam int IDX_W       = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_TEXT_FIRST   = 3'd0;
    localparam logic [IDX_W-1:0] REG_TEXT_END     = 3'd1;
    localparam logic [IDX_W-1:0] REG_RODATA_FIRST = 3'd2;
    localparam logic [IDX_W-1:0] REG_RODATA_END   = 3'd3;
    localparam logic [IDX_W-1:0] REG_USER_FIRST   = 3'd4;
    localparam logic [IDX_W-1:0] REG_USER_END     = 3'd5;

    // Fixed user stack pages (byte address >> page shift)
    localparam logic [CMP_W-1:0] STACK_A_PAGE = CMP_W'(64'h001F_E000 >> PAGE_SHIFT);
    localparam logic [CMP_W-1:0] STACK_B_PAGE = CMP_W'(64'h001F_C000 >> PAGE_SHIFT);
    localparam logic [CMP_W-1:0] STACK_C_PAGE = CMP_W'(64'h001F_A000 >> PAGE_SHIFT);

    typedef logic [PAGE_W-1:0] page_t;

    // Region registers, stops exclusive
    typedef struct packed {
        logic [REG_W-1:0] text_first;
        logic [REG_W-1:0] text_stop;
        logic [REG_W-1:0] rodata_first;
        logic [REG_W-1:0] rodata_stop;
        logic [REG_W-1:0] user_first;
        logic [REG_W-1:0] user_stop;
    } cfg_t;

    // Request from the sequencer to the page classifier
    typedef struct packed {
        page_t page;
        logic  wr;
    } page_req_t;

endpackage

// ===== rtl/urppc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urppc_cfg_regs
// Six region registers written through a plain write port.
// ----------------------------------------------------------------------------
module urppc_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [urppc_pkg::IDX_W-1:0] cfg_index,
    input  logic [urppc_pkg::REG_W-1:0] cfg_wdata,
    output urppc_pkg::cfg_t             cfg
);

    urppc_pkg::cfg_t cfg_reg;
    urppc_pkg::cfg_t cfg_next;

    // Register decode; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                urppc_pkg::REG_TEXT_FIRST:   cfg_next.text_first   = cfg_wdata;
                urppc_pkg::REG_TEXT_END:     cfg_next.text_stop    = cfg_wdata;
                urppc_pkg::REG_RODATA_FIRST: cfg_next.rodata_first = cfg_wdata;
                urppc_pkg::REG_RODATA_END:   cfg_next.rodata_stop  = cfg_wdata;
                urppc_pkg::REG_USER_FIRST:   cfg_next.user_first   = cfg_wdata;
                urppc_pkg::REG_USER_END:     cfg_next.user_stop    = cfg_wdata;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/urppc_page_class.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urppc_page_class
// Shared compare unit: classifies one page per cycle by the boot map rules.
// ----------------------------------------------------------------------------
module urppc_page_class (
    input  urppc_pkg::cfg_t      cfg,
    input  urppc_pkg::page_req_t req,
    output logic                 allow
);

    logic [urppc_pkg::CMP_W-1:0] pg;
    logic in_text;
    logic in_rodata;
    logic in_user;
    logic is_stack;

    assign pg = urppc_pkg::CMP_W'(req.page);

    // Region hits, empty or inverted regions never match
    assign in_text   = (pg >= urppc_pkg::CMP_W'(cfg.text_first)) &&
                       (pg <  urppc_pkg::CMP_W'(cfg.text_stop));
    assign in_rodata = (pg >= urppc_pkg::CMP_W'(cfg.rodata_first)) &&
                       (pg <  urppc_pkg::CMP_W'(cfg.rodata_stop));
    assign in_user   = (pg >= urppc_pkg::CMP_W'(cfg.user_first)) &&
                       (pg <  urppc_pkg::CMP_W'(cfg.user_stop));
    assign is_stack  = (pg == urppc_pkg::STACK_A_PAGE) ||
                       (pg == urppc_pkg::STACK_B_PAGE) ||
                       (pg == urppc_pkg::STACK_C_PAGE);

    // Priority: null page, kernel text, kernel rodata, user text, stack
    always_comb begin
        if (pg == '0) begin
            allow = 1'b0;
        end else if (in_text || in_rodata) begin
            allow = 1'b0;
        end else if (in_user) begin
            allow = !req.wr;
        end else begin
            allow = is_stack;
        end
    end

endmodule

// ===== rtl/urppc_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urppc_seq
// Sequencer: range setup, page walk over the shared classifier, result hold.
// ----------------------------------------------------------------------------
module urppc_seq (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [urppc_pkg::ADDR_W-1:0] s_address,
    input  logic [urppc_pkg::ADDR_W-1:0] s_length,
    input  logic                         s_write_access,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_range_ok,
    output urppc_pkg::page_req_t         req,
    input  logic                         allow
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SUM   = 3'd1;
    localparam logic [2:0] ST_LIMIT = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic [urppc_pkg::ADDR_W-1:0] address_reg, address_next;
    logic [urppc_pkg::ADDR_W-1:0] length_reg, length_next;
    logic                         wr_reg, wr_next;
    logic [urppc_pkg::ADDR_W-1:0] sum_reg, sum_next;
    urppc_pkg::page_t             page_reg, page_next;
    urppc_pkg::page_t             last_reg, last_next;
    logic                         ok_reg, ok_next;

    logic [urppc_pkg::ADDR_W:0]   sum_full;
    logic [urppc_pkg::ADDR_W-1:0] end_addr;
    logic [urppc_pkg::VPN_W-1:0]  last_vpn;

    assign sum_full = {1'b0, address_reg} + {1'b0, length_reg};
    assign end_addr = sum_reg - urppc_pkg::ADDR_W'(1);
    assign last_vpn = end_addr[urppc_pkg::ADDR_W-1:urppc_pkg::PAGE_SHIFT];

    // Next state and datapath
    always_comb begin
        state_next   = state_reg;
        address_next = address_reg;
        length_next  = length_reg;
        wr_next      = wr_reg;
        sum_next     = sum_reg;
        page_next    = page_reg;
        last_next    = last_reg;
        ok_next      = ok_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    address_next = s_address;
                    length_next  = s_length;
                    wr_next      = s_write_access;
                    state_next   = ST_SUM;
                end
            end
            ST_SUM: begin
                // zero length or wrap past the top of the address space
                sum_next = sum_full[urppc_pkg::ADDR_W-1:0];
                if ((length_reg == '0) || sum_full[urppc_pkg::ADDR_W]) begin
                    ok_next    = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_LIMIT;
                end
            end
            ST_LIMIT: begin
                // last page beyond the window; first page then is inside it
                if (last_vpn >= urppc_pkg::VPN_W'(urppc_pkg::TABLE_PAGES)) begin
                    ok_next    = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    page_next  = address_reg[urppc_pkg::PAGE_SHIFT +: urppc_pkg::PAGE_W];
                    last_next  = last_vpn[urppc_pkg::PAGE_W-1:0];
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // one page per cycle, stop at the first denied page
                if (!allow) begin
                    ok_next    = 1'b0;
                    state_next = ST_DONE;
                end else if (page_reg == last_reg) begin
                    ok_next    = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    page_next = page_reg + urppc_pkg::PAGE_W'(1);
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge aclk) begin
        address_reg <= address_next;
        length_reg  <= length_next;
        wr_reg      <= wr_next;
        sum_reg     <= sum_next;
        page_reg    <= page_next;
        last_reg    <= last_next;
        ok_reg      <= ok_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = (state_reg == ST_DONE);
    assign m_range_ok = ok_reg;
    assign req.page   = page_reg;
    assign req.wr     = wr_reg;

endmodule

// ===== rtl/user_range_page_permission_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// user_range_page_permission_check
// Checks that every page a user buffer touches permits user access.
// ----------------------------------------------------------------------------
// Steps from input transfer to result valid: the sum step ends a zero length or
// wrapping range, the limit step ends a range that leaves the window, else the
// page walk checks each page in turn (1 up to TABLE_PAGES pages) and stops at
// the first denied page. The walk runs through the single classifier, one item
// at a time; a new item is taken in the cycle after the result transfer.
// Reset: region registers clear to 0, sequencer returns to idle.
module user_range_page_permission_check (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [urppc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [urppc_pkg::REG_W-1:0]  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [urppc_pkg::ADDR_W-1:0] s_address,
    input  logic [urppc_pkg::ADDR_W-1:0] s_length,
    input  logic                         s_write_access,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_range_ok
);

    urppc_pkg::cfg_t      cfg;
    urppc_pkg::page_req_t req;
    logic                 allow;

    urppc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    urppc_page_class u_page_class (
        .cfg   (cfg),
        .req   (req),
        .allow (allow)
    );

    urppc_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_address      (s_address),
        .s_length       (s_length),
        .s_write_access (s_write_access),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_range_ok     (m_range_ok),
        .req            (req),
        .allow          (allow)
    );

endmodule

// ===== rtl/urppc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urppc_checker
// Port level checks for the user range page permission check.
// ----------------------------------------------------------------------------
module urppc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [urppc_pkg::ADDR_W-1:0] s_length,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_range_ok
);

    // One item in flight: never ready for input while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    // After an input transfer the block is busy and no result shows yet
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && !m_valid))
        else $error("busy state not entered after input transfer");

    // Exactly one result per item: it drops right after its transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> !m_valid)
        else $error("result repeated after transfer");

    // A zero length buffer is rejected straight after the sum step, with no page walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_length == '0)) |-> ##2 (m_valid && !m_range_ok))
        else $error("zero length not rejected");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_range_ok)))
        else $error("stalled result changed");

endmodule

bind user_range_page_permission_check urppc_checker u_urppc_checker (.*);
